// ===== rtl/core/tri_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the timed record interpolator.
package tri_pkg;

  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = 40;
  localparam int ZW = 33;
  localparam int STEPS = 16;
  localparam int SW = $clog2(STEPS);
  localparam int LIMW = 20;

  localparam logic [14:0] DIR_FULL = 15'd23040;
  localparam logic signed [ZW-1:0] ANG_90 = 33'sd377487360;
  localparam logic signed [ZW-1:0] ANG_180 = 33'sd754974720;
  localparam logic signed [ZW-1:0] ANG_360 = 33'sd1509949440;
  localparam logic signed [DW-1:0] GAIN_SQ = 40'sd395948874;

  localparam logic CFG_FALLBACK = 1'b0;
  localparam logic CFG_SPAN = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_INSERT,
    K_QUERY,
    K_CLEAR,
    K_INVALID
  } kind_t;

  // one stored record; layout matches the input data word
  typedef struct packed {
    logic [11:0] src;
    logic [15:0] height;
    logic [14:0] dir;
    logic [15:0] speed;
    logic [31:0] rtime;
  } rec_t;

  typedef struct packed {
    kind_t kind;
    rec_t  rec;
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIV,
    S_RD_B,
    S_RD_A,
    S_LOAD_A,
    S_ROT_INIT,
    S_ROT,
    S_MAC,
    S_VEC_INIT,
    S_VEC,
    S_MAG0,
    S_MAG1,
    S_RD_ONE,
    S_GRAB,
    S_FINISH
  } state_t;

  // atan(2^-i) in units of 2^-22 degree
  function automatic logic signed [ZW-1:0] atan_step(input logic [SW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:  r = 33'sd188743680;
      4'd1:  r = 33'sd111421900;
      4'd2:  r = 33'sd58872272;
      4'd3:  r = 33'sd29884485;
      4'd4:  r = 33'sd15000234;
      4'd5:  r = 33'sd7507429;
      4'd6:  r = 33'sd3754631;
      4'd7:  r = 33'sd1877430;
      4'd8:  r = 33'sd938729;
      4'd9:  r = 33'sd469366;
      4'd10: r = 33'sd234683;
      4'd11: r = 33'sd117342;
      4'd12: r = 33'sd58671;
      4'd13: r = 33'sd29336;
      4'd14: r = 33'sd14668;
      4'd15: r = 33'sd7334;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/timed_record_interpolator.sv =====
// Top level of the timed wind record table with time interpolation.
//
// Input stream (s_axis): one word per command; tuser carries the operation
// (insert, query, clear), tdata the record time and, for inserts, speed,
// direction, height and the three source codes. A two-entry command queue
// in front of the engine holds the sender only when it is full.
// Output stream (m_axis): exactly one word per command, in order; tuser holds
// the status, tdata speed, direction, height, sources and the count. The result
// waits in an output register; while it stalls, the engine still takes the next
// command and works on it up to its own result.
// Insert, clear and an invalid code need no table search; the queue takes the next
// command while the engine is still busy. A query scans one entry per cycle and
// ends early on an exact match; a one-sided answer or a refusal follows the scan.
// Blending takes 17 divider steps, two 16-step CORDIC rotations, 6 multiplier
// passes, a 16-step vectoring and 2 magnitude passes; a zero vector ends before
// the vectoring.
// Reset empties the table (records beyond the count are never read) and loads
// the fallback limit with 10800 s and the span limit with 86400 s.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once.
module timed_record_interpolator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // time[31:0] speed[47:32] direction[62:48] height[78:63]
  // speed_src[82:79] dir_src[86:83] height_src[90:87], zero fill
  input  logic [95:0]              s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // speed[15:0] direction[30:16] height[46:31] speed_src[50:47]
  // dir_src[54:51] height_src[58:55] stored_count[65:59], zero fill
  output logic [71:0]              m_axis_tdata,
  // status[1:0]
  output logic [1:0]               m_axis_tuser,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [tri_pkg::LIMW-1:0] cfg_data
);
  import tri_pkg::*;

  cmd_t head;
  logic head_valid;
  logic pop;

  // classify and queue incoming words
  tri_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop)
  );

  // table, search and interpolation engine
  tri_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/core/tri_front.sv =====
// Front end: takes input words, classifies the operation and queues commands.
module tri_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [95:0]      s_axis_tdata,
  input  logic [1:0]       s_axis_tuser,
  output logic             head_valid,
  output tri_pkg::cmd_t    head,
  input  logic             pop
);
  import tri_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.rec = rec_t'(s_axis_tdata[$bits(rec_t)-1:0]);
    if (cmd_in.rec.dir >= DIR_FULL) begin
      cmd_in.rec.dir = cmd_in.rec.dir - DIR_FULL;
    end
    unique case (s_axis_tuser)
      OP_INSERT: cmd_in.kind = K_INSERT;
      OP_QUERY:  cmd_in.kind = K_QUERY;
      OP_CLEAR:  cmd_in.kind = K_CLEAR;
      default:   cmd_in.kind = K_INVALID;
    endcase
  end

  assign s_axis_tready = (fill != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign head_valid = (fill != 2'd0);
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/tri_back.sv =====
// Back end: record table, scan, divider, CORDIC, blending and result register.
module tri_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  tri_pkg::cmd_t             head,
  output logic                      pop,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [tri_pkg::LIMW-1:0]  cfg_data,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [71:0]               m_axis_tdata,
  output logic [1:0]                m_axis_tuser
);
  import tri_pkg::*;

  state_t state, state_next;

  rec_t            mem [DEPTH];
  rec_t            rd_data;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;

  logic [CW-1:0]   count;
  logic [LIMW-1:0] fb_lim;
  logic [LIMW-1:0] sp_lim;
  cmd_t            cur;

  // scan
  logic [CW-1:0]   iss;
  logic [AW-1:0]   cidx;
  logic [AW-1:0]   midx;
  logic            hb, ha;
  logic [AW-1:0]   bi, ai;
  logic [31:0]     tb, ta;
  logic            scan_hit, scan_last;

  // evaluation
  logic [31:0]     gap, span, dlt;
  logic            ev_none, ev_one, ev_one_ok, ev_span_ok;

  // divider
  logic [20:0]     rem, den;
  logic [16:0]     lowbits;
  logic [4:0]      k;
  logic [21:0]     rem_sh;
  logic            div_ge;
  logic [16:0]     al, bl;

  rec_t            rec_b, rec_a;

  // CORDIC
  logic signed [DW-1:0] cx, cy, nx, ny, sx, sy;
  logic signed [ZW-1:0] cz, nz, at;
  logic [SW-1:0]        it;
  logic                 lane, flip;
  logic                 cw;
  logic signed [ZW-1:0] z0, z1;
  rec_t                 rin;

  logic signed [DW-1:0] xb, yb, xa, ya, vx, vy;

  // multiplier
  logic [2:0]           mcnt;
  logic signed [17:0]   mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [57:0]   mul_p;
  logic signed [57:0]   acc;
  logic signed [58:0]   mac_sum, mag_sum;
  logic [29:0]          mag;
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   qd;
  logic [15:0]          hres;

  // result
  status_t     res_status;
  logic [15:0] res_speed;
  logic [14:0] res_dir;
  logic [15:0] res_height;
  logic [11:0] res_src;
  logic        out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= cur.rec;
    end
    rd_data <= mem[mem_raddr];
  end

  // scan compare
  assign scan_hit = (rd_data.rtime == cur.rec.rtime);
  assign scan_last = ({1'b0, cidx} == count - CW'(1));

  // one-sided and two-sided checks
  assign gap = ha ? (ta - cur.rec.rtime) : (cur.rec.rtime - tb);
  assign span = ta - tb;
  assign dlt = cur.rec.rtime - tb;
  assign ev_none = !ha && !hb;
  assign ev_one = ha != hb;
  assign ev_one_ok = gap <= {{(32-LIMW){1'b0}}, fb_lim};
  assign ev_span_ok = span <= {{(32-LIMW){1'b0}}, sp_lim};

  assign rem_sh = {rem, lowbits[k]};
  assign div_ge = rem_sh >= {1'b0, den};
  assign bl = 17'(17'h10000 - al);

  // CORDIC step, rotation drives z to zero, vectoring drives y to zero
  assign sx = cx >>> it;
  assign sy = cy >>> it;
  assign at = atan_step(it);
  assign cw = (state == S_ROT) ? (cz >= 0) : (cy < 0);
  always_comb begin
    if (cw) begin
      nx = cx - sy;
      ny = cy + sx;
      nz = cz - at;
    end else begin
      nx = cx + sy;
      ny = cy - sx;
      nz = cz + at;
    end
  end

  // fold the start angle into [-90, 90] degrees
  assign rin = lane ? rec_a : rec_b;
  always_comb begin
    z0 = signed'({2'b0, rin.dir, 16'b0});
    if (z0 >= ANG_180) begin
      z0 = z0 - ANG_360;
    end
    z1 = z0;
    if (z0 > ANG_90) begin
      z1 = z0 - ANG_180;
    end else if (z0 < -ANG_90) begin
      z1 = z0 + ANG_180;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = signed'({1'b0, al});
    mul_b = xa;
    if (state == S_MAG0) begin
      mul_a = signed'({1'b0, cx[16:0]});
      mul_b = GAIN_SQ;
    end else if (state == S_MAG1) begin
      mul_a = signed'({1'b0, cx[33:17]});
      mul_b = GAIN_SQ;
    end else begin
      unique case (mcnt)
        3'd0: begin
          mul_a = signed'({1'b0, bl});
          mul_b = xb;
        end
        3'd1: begin
          mul_a = signed'({1'b0, al});
          mul_b = xa;
        end
        3'd2: begin
          mul_a = signed'({1'b0, bl});
          mul_b = yb;
        end
        3'd3: begin
          mul_a = signed'({1'b0, al});
          mul_b = ya;
        end
        3'd4: begin
          mul_a = signed'({1'b0, bl});
          mul_b = signed'({24'b0, rec_b.height});
        end
        3'd5: begin
          mul_a = signed'({1'b0, al});
          mul_b = signed'({24'b0, rec_a.height});
        end
        default: begin
          mul_a = signed'({1'b0, al});
          mul_b = xa;
        end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;
  assign mac_sum = 59'(acc) + 59'(mul_p) + 59'sd32768;
  // rounding of x*gain split over two 17-bit chunks
  assign mag_sum = 59'(acc >>> 17) + 59'(mul_p) + 59'sd268435456;
  assign mag = mag_sum[58:29];
  assign zr = cz + 33'sd32768;
  always_comb begin
    qd = zr[ZW-1:16];
    if (qd < 0) begin
      qd = qd + 17'sd23040;
    end else if (qd >= 17'sd23040) begin
      qd = qd - 17'sd23040;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          if (head.kind == K_QUERY && count != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_RD_ONE;
        end else if (scan_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (ev_none) begin
          state_next = S_FINISH;
        end else if (ev_one) begin
          state_next = ev_one_ok ? S_RD_ONE : S_FINISH;
        end else begin
          state_next = ev_span_ok ? S_DIV : S_FINISH;
        end
      end
      S_DIV:      state_next = (k == 5'd0) ? S_RD_B : S_DIV;
      S_RD_B:     state_next = S_RD_A;
      S_RD_A:     state_next = S_LOAD_A;
      S_LOAD_A:   state_next = S_ROT_INIT;
      S_ROT_INIT: state_next = S_ROT;
      S_ROT: begin
        if (it == SW'(STEPS - 1)) begin
          state_next = lane ? S_MAC : S_ROT_INIT;
        end
      end
      S_MAC:      state_next = (mcnt == 3'd5) ? S_VEC_INIT : S_MAC;
      S_VEC_INIT: state_next = (vx == '0 && vy == '0) ? S_FINISH : S_VEC;
      S_VEC:      state_next = (it == SW'(STEPS - 1)) ? S_MAG0 : S_VEC;
      S_MAG0:     state_next = S_MAG1;
      S_MAG1:     state_next = S_FINISH;
      S_RD_ONE:   state_next = S_GRAB;
      S_GRAB:     state_next = S_FINISH;
      S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    pop = 1'b0;
    mem_we = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE:   pop = head_valid;
      S_SCAN:   mem_raddr = iss[AW-1:0];
      S_RD_B:   mem_raddr = bi;
      S_RD_A:   mem_raddr = ai;
      S_RD_ONE: mem_raddr = midx;
      S_FINISH: mem_we = out_free && cur.kind == K_INSERT && res_status == ST_OK;
      default:  mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fb_lim <= LIMW'(10800);
      sp_lim <= LIMW'(86400);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FALLBACK) begin
          fb_lim <= cfg_data;
        end else begin
          sp_lim <= cfg_data;
        end
      end
      if (state == S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
        if (cur.kind == K_INSERT && res_status == ST_OK) begin
          count <= count + CW'(1);
        end else if (cur.kind == K_CLEAR) begin
          count <= '0;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur <= head;
        res_status <= ST_FAIL;
        res_speed <= '0;
        res_dir <= '0;
        res_height <= '0;
        res_src <= '0;
        iss <= CW'(1);
        cidx <= '0;
        hb <= 1'b0;
        ha <= 1'b0;
        if (head.kind == K_INSERT) begin
          res_status <= (count == CW'(DEPTH)) ? ST_FULL : ST_OK;
        end else if (head.kind == K_CLEAR) begin
          res_status <= ST_OK;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          midx <= cidx;
        end else if (rd_data.rtime < cur.rec.rtime) begin
          if (!hb || tb < rd_data.rtime) begin
            hb <= 1'b1;
            bi <= cidx;
            tb <= rd_data.rtime;
          end
        end else begin
          if (!ha || rd_data.rtime < ta) begin
            ha <= 1'b1;
            ai <= cidx;
            ta <= rd_data.rtime;
          end
        end
        cidx <= cidx + AW'(1);
        iss <= iss + CW'(1);
      end
      S_EVAL: begin
        midx <= ha ? ai : bi;
        // alpha = round(65536 * d / span) as (d*2^17 + span) / (2*span)
        rem <= 21'(dlt[LIMW-1:0]) + 21'(span[LIMW-1:17]);
        den <= {span[LIMW-1:0], 1'b0};
        lowbits <= span[16:0];
        k <= 5'd16;
        al <= '0;
      end
      S_DIV: begin
        rem <= div_ge ? 21'(rem_sh - {1'b0, den}) : rem_sh[20:0];
        al[k] <= div_ge;
        k <= k - 5'd1;
        lane <= 1'b0;
      end
      S_RD_A: rec_b <= rd_data;
      S_LOAD_A: rec_a <= rd_data;
      S_ROT_INIT: begin
        cx <= signed'({8'b0, rin.speed, 16'b0});
        cy <= '0;
        cz <= z1;
        flip <= (z0 > ANG_90) || (z0 < -ANG_90);
        it <= '0;
      end
      S_ROT: begin
        cx <= nx;
        cy <= ny;
        cz <= nz;
        it <= it + SW'(1);
        if (it == SW'(STEPS - 1)) begin
          if (lane) begin
            xa <= flip ? -nx : nx;
            ya <= flip ? -ny : ny;
          end else begin
            xb <= flip ? -nx : nx;
            yb <= flip ? -ny : ny;
          end
          lane <= 1'b1;
          mcnt <= '0;
        end
      end
      S_MAC: begin
        mcnt <= mcnt + 3'd1;
        if (!mcnt[0]) begin
          acc <= mul_p;
        end else if (mcnt == 3'd1) begin
          vx <= mac_sum[DW+15:16];
        end else if (mcnt == 3'd3) begin
          vy <= mac_sum[DW+15:16];
        end else begin
          hres <= mac_sum[31:16];
        end
      end
      S_VEC_INIT: begin
        res_status <= ST_OK;
        res_height <= hres;
        res_src <= rec_b.src;
        it <= '0;
        if (vx < 0) begin
          cx <= -vx;
          cy <= -vy;
          cz <= ANG_180;
        end else begin
          cx <= vx;
          cy <= vy;
          cz <= '0;
        end
      end
      S_VEC: begin
        cx <= nx;
        cy <= ny;
        cz <= nz;
        it <= it + SW'(1);
      end
      S_MAG0: acc <= mul_p;
      S_MAG1: begin
        res_speed <= (mag > 30'd65535) ? 16'hFFFF : mag[15:0];
        res_dir <= qd[14:0];
      end
      S_GRAB: begin
        res_status <= ST_OK;
        res_speed <= rd_data.speed;
        res_dir <= rd_data.dir;
        res_height <= rd_data.height;
        res_src <= rd_data.src;
      end
      S_FINISH: begin
        if (out_free) begin
          m_axis_tuser <= res_status;
          m_axis_tdata <= {6'b0,
                           (cur.kind == K_INSERT && res_status == ST_OK) ? count + CW'(1) :
                           (cur.kind == K_CLEAR) ? CW'(0) : count,
                           res_src, res_height, res_dir, res_speed};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/timed_record_interpolator_test.sv =====
// Self-checking stream testbench for the timed wind record interpolator.
module timed_record_interpolator_test;
  import tri_pkg::*;

  // operation code outside the defined set
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  // one result word as it leaves the block
  typedef struct packed {
    status_t     status;
    logic [15:0] spd;
    logic [14:0] dir;
    logic [15:0] hgt;
    logic [3:0]  ssrc;
    logic [3:0]  dsrc;
    logic [3:0]  hsrc;
    logic [6:0]  cnt;
  } answer_t;

  // one directed stimulus row; typed rows carry a hand-written answer
  typedef struct {
    logic [1:0]  op;
    logic [31:0] t;
    logic [15:0] spd;
    logic [14:0] dir;
    logic [15:0] hgt;
    logic [11:0] src;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [LIMW-1:0] cfg_data = '0;

  timed_record_interpolator u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the table and the limits
  logic [31:0] m_time [DEPTH];
  logic [15:0] m_spd  [DEPTH];
  logic [14:0] m_dir  [DEPTH];
  logic [15:0] m_hgt  [DEPTH];
  logic [11:0] m_src  [DEPTH];
  int          m_cnt;
  logic [LIMW-1:0] m_fallback, m_span;

  answer_t pending_answers[$];
  int      errors = 0;
  int      words_in = 0, words_out = 0, n_interp = 0, n_full = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      hold_req = 0;

  localparam longint ATAN_LUT [16] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29336,
    14668, 7334};

  // CORDIC rotation of (speed, 0) by the stored direction
  task automatic wind_vector(input logic [15:0] s, input logic [14:0] d,
                             output longint cx, output longint cy);
    longint z, x, y, nx, ny;
    bit flip;
    z = longint'(d) * 65536;
    x = longint'(s) * 65536;
    y = 0;
    flip = 0;
    if (z >= ANG_180) z -= ANG_360;
    if (z > ANG_90) begin
      z -= ANG_180; flip = 1;
    end else if (z < -ANG_90) begin
      z += ANG_180; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_LUT[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_LUT[i];
      end
      x = nx; y = ny;
    end
    cx = flip ? -x : x;
    cy = flip ? -y : y;
  endtask

  function automatic answer_t from_entry(int k);
    answer_t r;
    r = '0;
    r.status = ST_OK;
    r.spd = m_spd[k]; r.dir = m_dir[k]; r.hgt = m_hgt[k];
    r.ssrc = m_src[k][3:0]; r.dsrc = m_src[k][7:4]; r.hsrc = m_src[k][11:8];
    return r;
  endfunction

  task automatic lookup_wind(input logic [31:0] t, output answer_t r);
    int b, a;
    bit hb, ha;
    logic [31:0] gap;
    logic [63:0] span, dd, mag;
    longint al, bl, xb, yb, xa, ya, x, y, z, q, nx, ny;
    r = '0;
    r.status = ST_FAIL;
    b = 0; a = 0; hb = 0; ha = 0;
    for (int i = 0; i < m_cnt; i++) begin
      if (m_time[i] == t) begin
        r = from_entry(i);
        return;
      end
      if (m_time[i] < t) begin
        if (!hb || m_time[b] < m_time[i]) begin b = i; hb = 1; end
      end else begin
        if (!ha || m_time[i] < m_time[a]) begin a = i; ha = 1; end
      end
    end
    if (!ha || !hb) begin
      if (!ha && !hb) return;
      gap = ha ? m_time[a] - t : t - m_time[b];
      if (gap > m_fallback) return;
      r = from_entry(ha ? a : b);
      return;
    end
    span = 64'(m_time[a] - m_time[b]);
    dd = 64'(t - m_time[b]);
    if (span > m_span) return;
    al = longint'((dd * 131072 + span) / (2 * span));
    bl = 65536 - al;
    wind_vector(m_spd[b], m_dir[b], xb, yb);
    wind_vector(m_spd[a], m_dir[a], xa, ya);
    x = (bl * xb + al * xa + 32768) >>> 16;
    y = (bl * yb + al * ya + 32768) >>> 16;
    r = from_entry(b);
    if (x == 0 && y == 0) begin
      // blended vector vanished: calm, north
      r.spd = '0; r.dir = '0;
    end else begin
      z = 0;
      if (x < 0) begin x = -x; y = -y; z = ANG_180; end
      for (int j = 0; j < 16; j++) begin
        if (y >= 0) begin
          nx = x + (y >>> j); ny = y - (x >>> j); z += ATAN_LUT[j];
        end else begin
          nx = x - (y >>> j); ny = y + (x >>> j); z -= ATAN_LUT[j];
        end
        x = nx; y = ny;
      end
      mag = (64'(x) * 64'(GAIN_SQ) + (64'd1 << 45)) >> 46;
      r.spd = mag > 65535 ? 16'hFFFF : mag[15:0];
      q = ((z + 32768) >>> 16) % longint'(DIR_FULL);
      if (q < 0) q += longint'(DIR_FULL);
      r.dir = q[14:0];
    end
    r.hgt = 16'((bl * longint'(m_hgt[b]) + al * longint'(m_hgt[a]) + 32768) >>> 16);
    n_interp++;
  endtask

  // apply one accepted command to the model and return its answer
  task automatic apply_command(input logic [1:0] op, input logic [95:0] w,
                               output answer_t r);
    r = '0;
    r.status = ST_FAIL;
    case (op)
      OP_INSERT: begin
        if (m_cnt >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          m_time[m_cnt] = w[31:0];
          m_spd[m_cnt] = w[47:32];
          m_dir[m_cnt] = 15'(w[62:48] % DIR_FULL);
          m_hgt[m_cnt] = w[78:63];
          m_src[m_cnt] = w[90:79];
          m_cnt++;
          r.status = ST_OK;
        end
      end
      OP_QUERY: lookup_wind(w[31:0], r);
      OP_CLEAR: begin
        m_cnt = 0;
        r.status = ST_OK;
      end
      default: ;
    endcase
    r.cnt = 7'(m_cnt);
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] bad %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // output checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (pending_answers.size() == 0) begin
        note_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tuser != want.status) note_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[15:0] != want.spd) note_mismatch("speed", m_axis_tdata[15:0], want.spd);
        if (m_axis_tdata[30:16] != want.dir)
          note_mismatch("direction", m_axis_tdata[30:16], want.dir);
        if (m_axis_tdata[46:31] != want.hgt) note_mismatch("height", m_axis_tdata[46:31], want.hgt);
        if (m_axis_tdata[50:47] != want.ssrc)
          note_mismatch("speed source", m_axis_tdata[50:47], want.ssrc);
        if (m_axis_tdata[54:51] != want.dsrc)
          note_mismatch("direction source", m_axis_tdata[54:51], want.dsrc);
        if (m_axis_tdata[58:55] != want.hsrc)
          note_mismatch("height source", m_axis_tdata[58:55], want.hsrc);
        if (m_axis_tdata[65:59] != want.cnt) note_mismatch("count", m_axis_tdata[65:59], want.cnt);
        if (m_axis_tdata[71:66] != '0) note_mismatch("fill bits", m_axis_tdata[71:66], 0);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    static int quiet = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= 20000) begin
      $display("watchdog expired, %0d answers outstanding", pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offer one command word; returns at the accepting edge (plus any idle gap)
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] t,
                          input logic [15:0] spd, input logic [14:0] dir,
                          input logic [15:0] hgt, input logic [11:0] src,
                          input bit typed, input answer_t typed_ans);
    logic [95:0] w;
    answer_t r;
    w = {5'd0, src, hgt, dir, spd, t};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    words_in++;
    apply_command(op, w, r);
    pending_answers = {pending_answers, (typed ? typed_ans : r)};
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic write_limit(input logic idx, input logic [LIMW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FALLBACK) m_fallback = v;
    else m_span = v;
    @(posedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic answer_t status_only(status_t s, int c);
    answer_t r;
    r = '0;
    r.status = s;
    r.cnt = 7'(c);
    return r;
  endfunction

  row_t plan[$];

  task automatic add_row(logic [1:0] op, logic [31:0] t, logic [15:0] spd,
                         logic [14:0] dir, logic [15:0] hgt, logic [11:0] src,
                         bit typed = 0, answer_t ans = '0);
    row_t r;
    r.op = op; r.t = t; r.spd = spd; r.dir = dir; r.hgt = hgt; r.src = src;
    r.typed = typed; r.ans = ans;
    plan = {plan, r};
  endtask

  // one random, mostly well-formed command
  task automatic random_cmd(inout logic [31:0] base);
    int roll;
    logic [31:0] t;
    logic [14:0] d;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 5) base = $urandom;
    d = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(23039));
    if (roll < 2) begin
      send_cmd(OP_CLEAR, $urandom, 16'($urandom), 15'($urandom), 16'($urandom),
               12'($urandom), 0, '0);
    end else if (roll < 4) begin
      send_cmd(OP_UNDEFINED, $urandom, 16'($urandom), 15'($urandom), 16'($urandom),
               12'($urandom), 0, '0);
    end else if (roll < 50) begin
      t = base + $urandom_range(40000);
      if ($urandom_range(19) == 0) t = $urandom;
      send_cmd(OP_INSERT, t, 16'($urandom), d, 16'($urandom), 12'($urandom), 0, '0);
    end else begin
      if (m_cnt > 0 && $urandom_range(99) < 25) t = m_time[$urandom_range(m_cnt - 1)];
      else if ($urandom_range(19) == 0) t = $urandom;
      else t = base + $urandom_range(60000) - 10000;
      send_cmd(OP_QUERY, t, 16'($urandom), 15'($urandom), 16'($urandom),
               12'($urandom), 0, '0);
    end
  endtask

  initial begin
    logic [31:0] base;
    int wait_cycles;
    m_cnt = 0;
    m_fallback = 10800;
    m_span = 86400;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset limits
    add_row(OP_QUERY, 32'd500, 0, 0, 0, 0, 1, status_only(ST_FAIL, 0));
    add_row(OP_UNDEFINED, 32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 12'hFFF, 1,
            status_only(ST_FAIL, 0));
    add_row(OP_INSERT, 32'd1000, 16'h0100, 15'd0, 16'd100, 12'h321, 1, status_only(ST_OK, 1));
    // duplicate time: earliest inserted wins the exact match
    add_row(OP_INSERT, 32'd1000, 16'h0200, 15'd5760, 16'd200, 12'h654, 1, status_only(ST_OK, 2));
    add_row(OP_QUERY, 32'd1000, 0, 0, 0, 0);
    add_row(OP_INSERT, 32'd5000, 16'hFFFF, 15'd23039, 16'hFFFF, 12'hFFF, 1,
            status_only(ST_OK, 3));
    // out-of-range direction wraps on store
    add_row(OP_INSERT, 32'd3000, 16'h1234, 15'h7FFF, 16'd0, 12'h000, 1, status_only(ST_OK, 4));
    add_row(OP_QUERY, 32'd2000, 0, 0, 0, 0);
    add_row(OP_QUERY, 32'd4000, 0, 0, 0, 0);
    add_row(OP_QUERY, 32'd3000, 0, 0, 0, 0);
    add_row(OP_QUERY, 32'd0, 0, 0, 0, 0);
    add_row(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, status_only(ST_FAIL, 4));
    // opposite winds cancel at the midpoint
    add_row(OP_INSERT, 32'd10000, 16'h0100, 15'd0, 16'd10, 12'h111, 1, status_only(ST_OK, 5));
    add_row(OP_INSERT, 32'd10002, 16'h0100, 15'd11520, 16'd30, 12'h222, 1,
            status_only(ST_OK, 6));
    add_row(OP_QUERY, 32'd10001, 0, 0, 0, 0);
    add_row(OP_CLEAR, 32'd0, 0, 0, 0, 0, 1, status_only(ST_OK, 0));
    add_row(OP_QUERY, 32'd1000, 0, 0, 0, 0, 1, status_only(ST_FAIL, 0));
    // equal-time neighbours
    add_row(OP_INSERT, 32'd20, 16'h0300, 15'd100, 16'd5, 12'hABC, 1, status_only(ST_OK, 1));
    add_row(OP_INSERT, 32'd20, 16'h0400, 15'd200, 16'd6, 12'hDEF, 1, status_only(ST_OK, 2));
    add_row(OP_INSERT, 32'd40, 16'h0500, 15'd22000, 16'd7, 12'h135, 1, status_only(ST_OK, 3));
    add_row(OP_QUERY, 32'd30, 0, 0, 0, 0);
    add_row(OP_QUERY, 32'd0, 0, 0, 0, 0);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 15'd0, 16'h0000, 12'h000, 1,
            status_only(ST_OK, 4));
    add_row(OP_QUERY, 32'hFFFF_0000, 0, 0, 0, 0);
    foreach (plan[i])
      send_cmd(plan[i].op, plan[i].t, plan[i].spd, plan[i].dir, plan[i].hgt, plan[i].src,
               plan[i].typed, plan[i].ans);
    drain();

    // random phases: limits and idling change only while the block is empty
    base = 32'd100000;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_limit(CFG_FALLBACK, 10800); write_limit(CFG_SPAN, 86400);
                 tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin write_limit(CFG_FALLBACK, 0); write_limit(CFG_SPAN, 0);
                 tx_idle_pct = 52; rx_stall_pct = 0; end
        2: begin write_limit(CFG_FALLBACK, 20'hFFFFF); write_limit(CFG_SPAN, 20'hFFFFF);
                 tx_idle_pct = 0; rx_stall_pct = 52; end
        3: begin write_limit(CFG_FALLBACK, 5000); write_limit(CFG_SPAN, 20000);
                 tx_idle_pct = 11; rx_stall_pct = 11; end
        default: begin write_limit(CFG_FALLBACK, 30000); write_limit(CFG_SPAN, 40000);
                 tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      for (int n = 0; n < 320; n++) begin
        // long receiver hold-off with the sender pushing hard
        if (ph == 4 && n == 40) hold_req <= hold_req + 1;
        random_cmd(base);
      end
      drain();
    end

    wait_cycles = 0;
    while (pending_answers.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (pending_answers.size() != 0) begin
      errors++;
      $display("%0d answers never arrived", pending_answers.size());
    end
    $display("Sent %0d commands, checked %0d answers; %0d interpolations, %0d full-table refusals",
             words_in, words_out, n_interp, n_full);
    $display("Covered five limit settings, sender and receiver idling, and a long output stall");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
